[rtl/gof_pkg.sv]
// Shared constants and register codes for the gradient optical flow pixel block.
// No dependencies.
package gof_pkg;

    localparam int OUT_W      = 24;
    localparam int SCALE_W    = 16;
    localparam int REG_W      = 16;
    localparam int LEN_W      = 24;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;
    localparam int MAG_FRAC   = 8;

    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd2560;
    localparam logic [REG_W-1:0]   REGUL_RST = 16'd163;
    localparam logic [LEN_W-1:0]   LEN_RST   = 24'd65280;

    typedef enum logic [1:0] {
        REG_FLOW_SCALE  = 2'd0,
        REG_REGULARIZER = 2'd1,
        REG_MIN_LENGTH  = 2'd2,
        REG_NONE        = 2'd3
    } reg_idx_t;

endpackage

[rtl/gof_pix_if.sv]
// Input channel: one pixel neighborhood from two frames.
// Depends on nothing.
interface gof_pix_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] cur_center;
    logic [W-1:0] prev_center;
    logic [W-1:0] cur_left;
    logic [W-1:0] cur_right;
    logic [W-1:0] cur_above;
    logic [W-1:0] cur_below;
    logic [W-1:0] prev_left;
    logic [W-1:0] prev_right;
    logic [W-1:0] prev_above;
    logic [W-1:0] prev_below;

    modport source (output valid, cur_center, prev_center, cur_left, cur_right, cur_above,
                    cur_below, prev_left, prev_right, prev_above, prev_below, input ready);
    modport sink (input valid, cur_center, prev_center, cur_left, cur_right, cur_above,
                  cur_below, prev_left, prev_right, prev_above, prev_below, output ready);
endinterface

[rtl/gof_flow_if.sv]
// Output channel: split flow components in 16.8 fixed point.
// Uses gof_pkg for the field width.
interface gof_flow_if;
    logic                      valid;
    logic                      ready;
    logic [gof_pkg::OUT_W-1:0] flow_x_pos;
    logic [gof_pkg::OUT_W-1:0] flow_x_neg;
    logic [gof_pkg::OUT_W-1:0] flow_y_pos;
    logic [gof_pkg::OUT_W-1:0] flow_y_neg;

    modport source (output valid, flow_x_pos, flow_x_neg, flow_y_pos, flow_y_neg,
                    input ready);
    modport sink (input valid, flow_x_pos, flow_x_neg, flow_y_pos, flow_y_neg,
                  output ready);
endinterface

[rtl/gradient_optical_flow_pixel_top.sv]
// Top level of the per-pixel gradient optical flow block: APB registers,
// front-end gradient math, threshold and output. Uses gof_pkg, gof_sqrt, gof_div.
//
// Usage: pix (sink) takes one neighborhood transfer per cycle while pix.ready
// is high: center and four neighbors of the current and previous frame. flow
// (source) gives one transfer per input with the split, scaled flow in
// unsigned 16.8 fixed point. The pipeline has three front stages, one stage
// per root bit of the magnitude square root, a setup stage plus one stage per
// quotient bit in the dividers, then a square stage and the output register.
// When the flow receiver holds ready low with a result waiting, the whole
// pipeline holds and pix.ready drops in the same cycle; nothing is lost.
// Reset empties the pipeline and loads flow_scale 10.0, regularizer 163,
// min_length 255.0. Registers sit at byte addresses 0, 4 and 8; write them
// only while no transfer is in flight.
module gradient_optical_flow_pixel_top #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gof_pkg::APB_AW-1:0]  paddr,
    input  logic [gof_pkg::APB_DW-1:0]  pwdata,
    output logic [gof_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    gof_pix_if.sink                     pix,
    gof_flow_if.source                  flow
);
    localparam int P      = PIXEL_BITS;
    localparam int DW     = P + 1;
    localparam int GW     = P + 2;
    localparam int SQW    = 2 * P + 2;
    localparam int AW     = 2 * P + 1;
    localparam int SW     = 2 * P + 4;
    localparam int NW     = AW + gof_pkg::SCALE_W;
    localparam int RAD_W  = SW + 2 * gof_pkg::MAG_FRAC;
    localparam int MW     = RAD_W / 2;
    localparam int NUMW   = NW + gof_pkg::MAG_FRAC;
    localparam int OW     = gof_pkg::OUT_W;

    // ---------------- configuration ----------------
    logic [gof_pkg::SCALE_W-1:0]  scale_reg;
    logic [gof_pkg::REG_W-1:0]    regul_reg;
    logic [gof_pkg::LEN_W-1:0]    len_reg;
    logic [2*gof_pkg::LEN_W-1:0]  len_sq_reg;
    gof_pkg::reg_idx_t            idx;

    assign pready = 1'b1;
    assign idx    = gof_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= gof_pkg::SCALE_RST;
            regul_reg <= gof_pkg::REGUL_RST;
            len_reg   <= gof_pkg::LEN_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                gof_pkg::REG_FLOW_SCALE:  scale_reg <= pwdata[gof_pkg::SCALE_W-1:0];
                gof_pkg::REG_REGULARIZER: regul_reg <= pwdata[gof_pkg::REG_W-1:0];
                gof_pkg::REG_MIN_LENGTH:  len_reg   <= pwdata[gof_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        len_sq_reg <= len_reg * len_reg;
    end

    always_comb
    begin
        unique case (idx)
            gof_pkg::REG_FLOW_SCALE:  prdata = gof_pkg::APB_DW'(scale_reg);
            gof_pkg::REG_REGULARIZER: prdata = gof_pkg::APB_DW'(regul_reg);
            gof_pkg::REG_MIN_LENGTH:  prdata = gof_pkg::APB_DW'(len_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic out_valid_reg;

    assign en        = !out_valid_reg || flow.ready;
    assign pix.ready = en;

    // ---------------- stage A: differences ----------------
    logic                 a_valid_reg;
    logic signed [DW-1:0] a_dif_reg;
    logic signed [GW-1:0] a_gx_reg;
    logic signed [GW-1:0] a_gy_reg;

    function automatic logic signed [GW-1:0] ext(input logic [P-1:0] v);
        return $signed({2'b00, v});
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= pix.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dif_reg <= $signed({1'b0, pix.prev_center}) - $signed({1'b0, pix.cur_center});
            a_gx_reg  <= (ext(pix.prev_right) - ext(pix.prev_left))
                       + (ext(pix.cur_right) - ext(pix.cur_left));
            a_gy_reg  <= (ext(pix.prev_below) - ext(pix.prev_above))
                       + (ext(pix.cur_below) - ext(pix.cur_above));
        end
    end

    // ---------------- stage B: products ----------------
    logic                      b_valid_reg;
    logic [SQW-1:0]            b_gx2_reg;
    logic [SQW-1:0]            b_gy2_reg;
    logic [AW-1:0]             b_ax_reg;
    logic [AW-1:0]             b_ay_reg;
    logic                      b_nx_reg;
    logic                      b_ny_reg;
    logic signed [DW+GW-1:0]   px;
    logic signed [DW+GW-1:0]   py;
    logic signed [2*GW-1:0]    gx2;
    logic signed [2*GW-1:0]    gy2;
    logic [DW+GW-1:0]          abs_x;
    logic [DW+GW-1:0]          abs_y;

    assign px    = a_dif_reg * a_gx_reg;
    assign py    = a_dif_reg * a_gy_reg;
    assign gx2   = a_gx_reg * a_gx_reg;
    assign gy2   = a_gy_reg * a_gy_reg;
    assign abs_x = px[DW+GW-1] ? -px : px;
    assign abs_y = py[DW+GW-1] ? -py : py;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_gx2_reg <= gx2[SQW-1:0];
            b_gy2_reg <= gy2[SQW-1:0];
            b_ax_reg  <= abs_x[AW-1:0];
            b_ay_reg  <= abs_y[AW-1:0];
            b_nx_reg  <= px[DW+GW-1];
            b_ny_reg  <= py[DW+GW-1];
        end
    end

    // ---------------- stage C: radicand and scaled numerators ----------------
    logic          c_valid_reg;
    logic [SW-1:0] c_s_reg;
    logic [NW-1:0] c_nx_reg;
    logic [NW-1:0] c_ny_reg;
    logic          c_sx_reg;
    logic          c_sy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_s_reg  <= SW'(b_gx2_reg) + SW'(b_gy2_reg) + SW'(regul_reg);
            c_nx_reg <= b_ax_reg * scale_reg;
            c_ny_reg <= b_ay_reg * scale_reg;
            c_sx_reg <= b_nx_reg;
            c_sy_reg <= b_ny_reg;
        end
    end

    // ---------------- magnitude square root ----------------
    localparam int SIDE_W = 2 * NW + 2;
    logic              m_valid;
    logic [MW-1:0]     m_root;
    logic [SIDE_W-1:0] m_side;

    gof_sqrt #(
        .IN_W   (RAD_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_val    ({c_s_reg, {(2 * gof_pkg::MAG_FRAC){1'b0}}}),
        .in_side   ({c_nx_reg, c_ny_reg, c_sx_reg, c_sy_reg}),
        .out_valid (m_valid),
        .out_root  (m_root),
        .out_side  (m_side)
    );

    // ---------------- dividers ----------------
    logic          dx_valid;
    logic          dy_valid;
    logic [OW-1:0] qx;
    logic [OW-1:0] qy;
    logic          sx;
    logic          sy;

    gof_div #(
        .NUM_W  (NUMW),
        .DEN_W  (MW),
        .Q_W    (OW),
        .SIDE_W (1)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .num       ({m_side[SIDE_W-1 -: NW], {gof_pkg::MAG_FRAC{1'b0}}}),
        .den       (m_root),
        .in_side   (m_side[1]),
        .out_valid (dx_valid),
        .quot      (qx),
        .out_side  (sx)
    );

    gof_div #(
        .NUM_W  (NUMW),
        .DEN_W  (MW),
        .Q_W    (OW),
        .SIDE_W (1)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .num       ({m_side[NW+1:2], {gof_pkg::MAG_FRAC{1'b0}}}),
        .den       (m_root),
        .in_side   (m_side[0]),
        .out_valid (dy_valid),
        .quot      (qy),
        .out_side  (sy)
    );

    // ---------------- stage D: squares for the length test ----------------
    logic            d_valid_reg;
    logic [OW-1:0]   d_qx_reg;
    logic [OW-1:0]   d_qy_reg;
    logic [2*OW-1:0] d_qx2_reg;
    logic [2*OW-1:0] d_qy2_reg;
    logic            d_sx_reg;
    logic            d_sy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= dx_valid && dy_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_qx_reg  <= qx;
            d_qy_reg  <= qy;
            d_qx2_reg <= qx * qx;
            d_qy2_reg <= qy * qy;
            d_sx_reg  <= sx;
            d_sy_reg  <= sy;
        end
    end

    // ---------------- output register ----------------
    logic            pass;
    logic [2*OW:0]   len2;
    logic [OW-1:0]   fx;
    logic [OW-1:0]   fy;
    logic [OW-1:0]   xpos_reg;
    logic [OW-1:0]   xneg_reg;
    logic [OW-1:0]   ypos_reg;
    logic [OW-1:0]   yneg_reg;

    assign len2 = (2*OW+1)'(d_qx2_reg) + (2*OW+1)'(d_qy2_reg);
    assign pass = len2 >= (2*OW+1)'(len_sq_reg);
    assign fx   = pass ? d_qx_reg : '0;
    assign fy   = pass ? d_qy_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xpos_reg <= d_sx_reg ? '0 : fx;
            xneg_reg <= d_sx_reg ? fx : '0;
            ypos_reg <= d_sy_reg ? '0 : fy;
            yneg_reg <= d_sy_reg ? fy : '0;
        end
    end

    assign flow.valid      = out_valid_reg;
    assign flow.flow_x_pos = xpos_reg;
    assign flow.flow_x_neg = xneg_reg;
    assign flow.flow_y_pos = ypos_reg;
    assign flow.flow_y_neg = yneg_reg;
endmodule

[rtl/gof_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with side payload.
// No package dependencies.
module gof_sqrt #(
    parameter int IN_W   = 36,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_val,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);
    localparam int RW = IN_W / 2;

    logic [RW-1:0]   valid_reg;
    logic [IN_W-1:0] v_reg    [RW];
    logic [RW-1:0]   r_reg    [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [SIDE_W-1:0] side_reg [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic              val_in;
        logic [IN_W-1:0]   v_in;
        logic [RW-1:0]     r_in;
        logic [RW+1:0]     rem_in;
        logic [SIDE_W-1:0] side_in;
        logic [RW+3:0]     cand;
        logic [RW+3:0]     trial;
        logic [RW+3:0]     sub;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign val_in  = in_valid;
            assign v_in    = in_val;
            assign r_in    = '0;
            assign rem_in  = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign val_in  = valid_reg[k-1];
            assign v_in    = v_reg[k-1];
            assign r_in    = r_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // bring down two bits, try subtracting 4r+1
        assign cand  = {rem_in, v_in[IN_W-1 -: 2]};
        assign trial = {2'b00, r_in, 2'b01};
        assign ge    = cand >= trial;
        assign sub   = cand - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= val_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]    <= {v_in[IN_W-3:0], 2'b00};
                r_reg[k]    <= {r_in[RW-2:0], ge};
                rem_reg[k]  <= ge ? sub[RW+1:0] : cand[RW+1:0];
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_root  = r_reg[RW-1];
    assign out_side  = side_reg[RW-1];
endmodule

[rtl/gof_div.sv]
// Pipelined restoring divider with saturation, one quotient bit per stage.
// Quotient is zero for a zero divisor, all ones when it would not fit.
module gof_div #(
    parameter int NUM_W  = 41,
    parameter int DEN_W  = 18,
    parameter int Q_W    = 24,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quot,
    output logic [SIDE_W-1:0] out_side
);
    localparam int W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

    // setup stage: flags for zero divisor and overflow
    logic              v0_reg;
    logic [W-1:0]      rem0_reg;
    logic [DEN_W-1:0]  den0_reg;
    logic              zero0_reg;
    logic              ovf0_reg;
    logic [SIDE_W-1:0] side0_reg;
    logic [W-1:0]      num_ext;
    logic [W-1:0]      den_top;

    assign num_ext = W'(num);
    assign den_top = W'(den) << Q_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem0_reg  <= num_ext;
            den0_reg  <= den;
            zero0_reg <= den == '0;
            ovf0_reg  <= num_ext >= den_top;
            side0_reg <= in_side;
        end
    end

    logic [Q_W-1:0]    valid_reg;
    logic [W-1:0]      rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    q_reg    [Q_W];
    logic [Q_W-1:0]    zero_reg;
    logic [Q_W-1:0]    ovf_reg;
    logic [SIDE_W-1:0] side_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic              val_in;
        logic [W-1:0]      rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    q_in;
        logic              zero_in;
        logic              ovf_in;
        logic [SIDE_W-1:0] side_in;
        logic [W-1:0]      sh;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign val_in  = v0_reg;
            assign rem_in  = rem0_reg;
            assign den_in  = den0_reg;
            assign q_in    = '0;
            assign zero_in = zero0_reg;
            assign ovf_in  = ovf0_reg;
            assign side_in = side0_reg;
        end
        else
        begin : g_next
            assign val_in  = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign zero_in = zero_reg[k-1];
            assign ovf_in  = ovf_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign sh = W'(den_in) << B;
        assign ge = rem_in >= sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= val_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? rem_in - sh : rem_in;
                den_reg[k]  <= den_in;
                q_reg[k]    <= {q_in[Q_W-2:0], ge};
                zero_reg[k] <= zero_in;
                ovf_reg[k]  <= ovf_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];
    always_comb
    begin
        priority if (zero_reg[Q_W-1])
            quot = '0;
        else if (ovf_reg[Q_W-1])
            quot = '1;
        else
            quot = q_reg[Q_W-1];
    end
endmodule

[dv/gradient_optical_flow_pixel_top_tb.sv]
// Testbench for gradient_optical_flow_pixel_top: random and directed pixel
// neighborhoods, APB register phases, scoreboard with its own flow predictor.
// Depends on gof_pkg, gof_pix_if, gof_flow_if and the RTL top.
`timescale 1ns / 1ps

module gradient_optical_flow_pixel_top_tb;

    typedef struct packed {
        logic [7:0] cc, pc, cl, cr, ca, cb, pl, pr, pa, pb;
    } nbhd_t;

    typedef struct packed {
        logic [gof_pkg::OUT_W-1:0] xp, xn, yp, yn;
    } flow_t;

    class flow_scoreboard;
        flow_t            pending[$];
        logic [15:0]      gain;
        logic [15:0]      lambda;
        logic [23:0]      thresh;
        int               errors;

        function void set_reg(gof_pkg::reg_idx_t idx, logic [31:0] val);
            case (idx)
                gof_pkg::REG_FLOW_SCALE:  gain = val[15:0];
                gof_pkg::REG_REGULARIZER: lambda = val[15:0];
                gof_pkg::REG_MIN_LENGTH:  thresh = val[23:0];
                default: ;
            endcase
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint unsigned part(longint d, longint g, longint unsigned m, output bit neg);
            longint p;
            longint unsigned a, q;
            p = d * g;
            neg = p < 0;
            a = p < 0 ? -p : p;
            if (a == 0 || m == 0)
                return 0;
            q = ((a * gain) << 8) / m;
            return q > 64'hFFFFFF ? 64'hFFFFFF : q;
        endfunction

        function void note_input(nbhd_t n);
            longint d, gx, gy;
            longint unsigned s, m, qx, qy;
            bit xn, yn;
            flow_t f;
            d = longint'(n.pc) - longint'(n.cc);
            gx = longint'(n.pr) - longint'(n.pl) + longint'(n.cr) - longint'(n.cl);
            gy = longint'(n.pb) - longint'(n.pa) + longint'(n.cb) - longint'(n.ca);
            s = gx * gx + gy * gy + lambda;
            m = root(s << 16);
            qx = part(d, gx, m, xn);
            qy = part(d, gy, m, yn);
            if (qx * qx + qy * qy < longint'(thresh) * longint'(thresh))
            begin
                qx = 0;
                qy = 0;
            end
            f.xp = gof_pkg::OUT_W'(xn ? 64'd0 : qx);
            f.xn = gof_pkg::OUT_W'(xn ? qx : 64'd0);
            f.yp = gof_pkg::OUT_W'(yn ? 64'd0 : qy);
            f.yn = gof_pkg::OUT_W'(yn ? qy : 64'd0);
            pending.push_back(f);
        endfunction

        function void check_result(flow_t got);
            flow_t exp_f;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected flow transfer %h", got);
                return;
            end
            exp_f = pending.pop_front();
            if (got !== exp_f)
            begin
                errors++;
                if (errors <= 10)
                    $display({"flow mismatch: exp xp=%h xn=%h yp=%h yn=%h",
                              " got xp=%h xn=%h yp=%h yn=%h"},
                             exp_f.xp, exp_f.xn, exp_f.yp, exp_f.yn,
                             got.xp, got.xn, got.yp, got.yn);
            end
        endfunction
    endclass

    localparam int LATENCY = 48;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [gof_pkg::APB_AW-1:0] paddr;
    logic [gof_pkg::APB_DW-1:0] pwdata, prdata;
    logic        pready;
    int          idle_pct;

    gof_pix_if  #(.W(8)) pix ();
    gof_flow_if          flow ();

    gradient_optical_flow_pixel_top dut (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .pix(pix.sink), .flow(flow.source)
    );

    flow_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    // receiver side with random stalls
    initial
    begin
        flow.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            flow.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && flow.valid && flow.ready)
            sb.check_result({flow.flow_x_pos, flow.flow_x_neg, flow.flow_y_pos, flow.flow_y_neg});

    task automatic apb_write(gof_pkg::reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= gof_pkg::APB_AW'(idx) << 2; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send(nbhd_t n);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            pix.valid <= 1'b0;
            @(negedge clk);
        end
        pix.valid <= 1'b1;
        {pix.cur_center, pix.prev_center, pix.cur_left, pix.cur_right, pix.cur_above,
         pix.cur_below, pix.prev_left, pix.prev_right, pix.prev_above, pix.prev_below} <= n;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        sb.note_input(n);
    endtask

    task automatic drain();
        int guard;
        @(negedge clk);
        pix.valid <= 1'b0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic nbhd_t rand_nbhd(int mode);
        nbhd_t n;
        n = 80'({$urandom, $urandom, $urandom});
        if (mode == 1)
        begin
            // moving edge: small difference between the centers, random neighbors
            n.cc = 8'($urandom_range(255));
            n.pc = n.cc + 8'($urandom_range(40)) - 8'd20;
        end
        return n;
    endfunction

    initial
    begin
        nbhd_t n;
        logic [31:0] vals[3];
        sb = new();
        sb.gain = gof_pkg::SCALE_RST;
        sb.lambda = gof_pkg::REGUL_RST;
        sb.thresh = gof_pkg::LEN_RST;
        idle_pct = 27;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        pix.valid = 1'b0;
        {pix.cur_center, pix.prev_center, pix.cur_left, pix.cur_right, pix.cur_above,
         pix.cur_below, pix.prev_left, pix.prev_right, pix.prev_above, pix.prev_below} = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed under reset settings, then with zero threshold and zero regularizer
        for (int ph = 0; ph < 2; ph++)
        begin
            send('0);
            send('1);
            send({8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255});
            send({8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0});
            send({8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0});
            send({8'd10, 8'd200, 8'd5, 8'd5, 8'd0, 8'd255, 8'd5, 8'd5, 8'd0, 8'd255});
            send({8'd100, 8'd100, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255});
            send({8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
            drain();
            if (ph == 0)
            begin
                apb_write(gof_pkg::REG_MIN_LENGTH, 32'd0);
                apb_write(gof_pkg::REG_REGULARIZER, 32'd0);
            end
        end
        // zero magnitude and saturation
        apb_write(gof_pkg::REG_FLOW_SCALE, 32'hFFFF);
        send({8'd0, 8'd255, {8{8'd7}}});
        send({8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        send({8'd255, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        drain();
        apb_write(gof_pkg::REG_REGULARIZER, 32'hFFFF);
        apb_write(gof_pkg::REG_MIN_LENGTH, 32'hFFFFFF);
        send({8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255});
        send(rand_nbhd(0));
        drain();

        // random phases with changing settings; phase 2 has no idling
        for (int ph = 0; ph < 6; ph++)
        begin
            vals[0] = (ph == 1) ? 32'd0 : $urandom_range(65535);
            vals[1] = (ph == 2) ? 32'd0 : $urandom_range(ph == 3 ? 65535 : 400);
            vals[2] = (ph == 4) ? 32'd0 : $urandom_range(ph == 5 ? 16777215 : 40000);
            apb_write(gof_pkg::REG_FLOW_SCALE, vals[0]);
            apb_write(gof_pkg::REG_REGULARIZER, vals[1]);
            apb_write(gof_pkg::REG_MIN_LENGTH, vals[2]);
            idle_pct = (ph == 2) ? 0 : 27;
            for (int i = 0; i < 105; i++)
            begin
                n = rand_nbhd($urandom_range(1));
                send(n);
            end
            drain();
        end
        idle_pct = 27;

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
